### sv/lbr_pkg.sv
`default_nettype none
package lbr_pkg;

    localparam int MAX_WORDS   = 64;
    localparam int IDX_W       = $clog2(MAX_WORDS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int CHAR_W      = 8;
    localparam int WIDTH_W     = 10;
    localparam int USED_W      = WIDTH_W + 1;
    localparam int SQ_W        = 2 * WIDTH_W;
    localparam int COST_W      = 27;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = WIDTH_W'(80);

    // One classified word on its way from the front to the back.
    typedef struct packed {
        logic [CHAR_W-1:0] chars;
        logic              para_end;
        logic              drop;
    } word_tok_t;

endpackage
`default_nettype wire

### sv/lbr_ifs.sv
`default_nettype none
interface lbr_word_if;
    import lbr_pkg::*;
    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   word_chars;
    logic                paragraph_end;
    modport source (output valid, word_chars, paragraph_end, input ready);
    modport sink   (input valid, word_chars, paragraph_end, output ready);
endinterface

interface lbr_res_if;
    import lbr_pkg::*;
    logic                valid;
    logic                ready;
    logic [WIDTH_W-1:0]  extra_spaces;
    logic                line_end;
    logic                last_word;
    logic                fit_error;
    modport source (output valid, extra_spaces, line_end, last_word, fit_error, input ready);
    modport sink   (input valid, extra_spaces, line_end, last_word, fit_error, output ready);
endinterface

interface lbr_cfg_if;
    import lbr_pkg::*;
    logic                valid;
    logic                ready;
    logic [WIDTH_W-1:0]  line_width;
    modport source (output valid, line_width, input ready);
    modport sink   (input valid, line_width, output ready);
endinterface
`default_nettype wire

### sv/min_raggedness_line_breaker.sv
// Minimum-raggedness line breaker.
// Words of one paragraph enter on word_in, one beat per word, as character
// counts; the beat with paragraph_end set closes the paragraph. Results leave
// on res_out, one beat per word in order, with the padding after the word,
// whether a line break follows it, and a last_word mark on the final beat.
// A paragraph with an oversized word or more than 64 words yields a single
// beat with fit_error set. cfg writes line_width, which is sampled when the
// closing word is processed; reset sets it to 80.
// Words are classified by the front and queued (four entries) to the back,
// which stores one word per cycle while it is loading. After the closing word,
// the back runs the dynamic program over one shared compare unit, one
// candidate line at a time, then sets out each line: it totals the words,
// divides the slack by the gaps for a padded line (and divides again when the
// slack does not split evenly over the gaps), and emits one beat per word at
// most per cycle.
// No new word enters the back while a paragraph is being solved or emitted.
// When res_out stalls, the output register holds its beat and the back waits.
// Reset empties the queue, clears the word count and leaves the output idle.
`default_nettype none
module min_raggedness_line_breaker (
    input  wire logic clk,
    input  wire logic rst_n,
    lbr_word_if.sink  word_in,
    lbr_res_if.source res_out,
    lbr_cfg_if.sink   cfg
);
    import lbr_pkg::*;

    logic [WIDTH_W-1:0] width_reg;
    word_tok_t          f_tok;
    logic               f_valid;
    logic               f_ready;
    word_tok_t          b_tok;
    logic               b_valid;
    logic               b_ready;

    // The register port never stalls.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= LINE_WIDTH_RESET;
        end
        else if (cfg.valid)
        begin
            width_reg <= cfg.line_width;
        end
    end

    lbr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .word_in   (word_in),
        .tok       (f_tok),
        .tok_valid (f_valid),
        .tok_ready (f_ready)
    );

    lbr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_tok   (f_tok),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_tok    (b_tok),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready)
    );

    lbr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (b_tok),
        .tok_valid (b_valid),
        .tok_ready (b_ready),
        .width     (width_reg),
        .res       (res_out)
    );

    // An error beat is always the single, closing beat of its paragraph.
    a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.fit_error |-> res_out.last_word && res_out.line_end)
        else $error("error beat without closing marks");

    // The last word of a paragraph always ends a line.
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.last_word |-> res_out.line_end)
        else $error("last word without line break");

    // Padding never follows the final word of a line.
    a_no_pad_at_break: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.line_end |-> res_out.extra_spaces == '0)
        else $error("padding after a line break");
endmodule
`default_nettype wire

### sv/lbr_front.sv
`default_nettype none
module lbr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    lbr_word_if.sink               word_in,
    output lbr_pkg::word_tok_t     tok,
    output logic                   tok_valid,
    input  wire logic              tok_ready
);
    import lbr_pkg::*;

    logic [CNT_W-1:0] fcnt_reg;
    logic             full;

    // A word beyond the storage depth is marked for dropping.
    assign full          = (fcnt_reg == CNT_W'(MAX_WORDS));
    assign tok.chars     = word_in.word_chars;
    assign tok.para_end  = word_in.paragraph_end;
    assign tok.drop      = full;
    assign tok_valid     = word_in.valid;
    assign word_in.ready = tok_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg <= '0;
        end
        else if (word_in.valid && tok_ready)
        begin
            if (word_in.paragraph_end)
            begin
                fcnt_reg <= '0;
            end
            else if (!full)
            begin
                fcnt_reg <= fcnt_reg + CNT_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

### sv/lbr_queue.sv
`default_nettype none
module lbr_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lbr_pkg::word_tok_t push_tok,
    input  wire logic              push_valid,
    output logic                   push_ready,
    output lbr_pkg::word_tok_t     pop_tok,
    output logic                   pop_valid,
    input  wire logic              pop_ready
);
    import lbr_pkg::*;

    word_tok_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QPTR_W:0]     fill_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_tok    = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + (QPTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - (QPTR_W+1)'(1);
            end
        end
    end
endmodule
`default_nettype wire

### sv/lbr_div.sv
`default_nettype none
module lbr_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [lbr_pkg::WIDTH_W-1:0]  dividend,
    input  wire logic [lbr_pkg::IDX_W-1:0]    divisor,
    output logic                              done,
    output logic [lbr_pkg::WIDTH_W-1:0]       quot,
    output logic [lbr_pkg::IDX_W-1:0]         rem
);
    import lbr_pkg::*;

    localparam int STEP_W = $clog2(WIDTH_W + 1);

    logic [WIDTH_W-1:0] acc_reg;
    logic [IDX_W-1:0]   rem_reg;
    logic [IDX_W-1:0]   dvs_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [IDX_W:0]     trial;
    logic               fits;

    // Restoring division, one quotient bit per cycle.
    assign trial = {rem_reg, acc_reg[WIDTH_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});
    assign done  = done_reg;
    assign quot  = acc_reg;
    assign rem   = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(WIDTH_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[WIDTH_W-2:0], fits};
            rem_reg <= fits ? IDX_W'(trial - {1'b0, dvs_reg}) : IDX_W'(trial);
        end
    end
endmodule
`default_nettype wire

### sv/lbr_back.sv
`default_nettype none
module lbr_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lbr_pkg::word_tok_t           tok,
    input  wire logic                         tok_valid,
    output logic                              tok_ready,
    input  wire logic [lbr_pkg::WIDTH_W-1:0]  width,
    lbr_res_if.source                         res
);
    import lbr_pkg::*;

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_DA   = 4'd2;
    localparam logic [3:0] S_DM   = 4'd3;
    localparam logic [3:0] S_DC   = 4'd4;
    localparam logic [3:0] S_DW   = 4'd5;
    localparam logic [3:0] S_EA   = 4'd6;
    localparam logic [3:0] S_EB   = 4'd7;
    localparam logic [3:0] S_SA   = 4'd8;
    localparam logic [3:0] S_SC   = 4'd9;
    localparam logic [3:0] S_DV1  = 4'd10;
    localparam logic [3:0] S_DV2  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [CHAR_W-1:0]  len_mem  [MAX_WORDS];
    logic [COST_W-1:0]  cost_mem [MAX_WORDS];
    logic [CNT_W-1:0]   brk_mem  [MAX_WORDS];
    logic [CHAR_W-1:0]  len_rd_reg;
    logic [COST_W-1:0]  cost_rd_reg;
    logic [CNT_W-1:0]   brk_rd_reg;
    logic [IDX_W-1:0]   len_raddr;

    logic [3:0]         st_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               ovf_reg;
    logic [CHAR_W-1:0]  maxc_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [WIDTH_W-1:0] w_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [USED_W-1:0]  used_reg;
    logic               have_reg;
    logic [COST_W-1:0]  best_reg;
    logic [CNT_W-1:0]   brk_reg;
    logic [SQ_W-1:0]    prod_reg;
    logic [CNT_W-1:0]   nxt_reg;
    logic [IDX_W-1:0]   gaps_reg;
    logic [WIDTH_W-1:0] q_reg;
    logic [IDX_W-1:0]   r_reg;
    logic [IDX_W-1:0]   d_reg;
    logic [IDX_W-1:0]   bon_reg;
    logic [IDX_W-1:0]   left_reg;
    logic               pad_line_reg;

    logic               o_valid_reg;
    logic [WIDTH_W-1:0] o_extra_reg;
    logic               o_le_reg;
    logic               o_lw_reg;
    logic               o_err_reg;

    logic               div_go_reg;
    logic [WIDTH_W-1:0] div_a_reg;
    logic [IDX_W-1:0]   div_b_reg;
    logic               div_done;
    logic [WIDTH_W-1:0] div_q;
    logic [IDX_W-1:0]   div_r;

    logic               out_free;
    logic [CHAR_W-1:0]  maxc_new;
    logic [USED_W-1:0]  used_dp;
    logic [USED_W-1:0]  used_sum;
    logic [WIDTH_W-1:0] slack_dp;
    logic               dp_last;
    logic [COST_W-1:0]  cost_now;
    logic [CNT_W-1:0]   nxt_raw;
    logic [CNT_W-1:0]   nxt_fix;
    logic               k_le;
    logic               bonus;

    lbr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    assign tok_ready = (st_reg == S_LOAD);
    assign out_free  = !o_valid_reg || res.ready;

    assign res.valid        = o_valid_reg;
    assign res.extra_spaces = o_extra_reg;
    assign res.line_end     = o_le_reg;
    assign res.last_word    = o_lw_reg;
    assign res.fit_error    = o_err_reg;

    assign len_raddr = (st_reg == S_SA) ? k_reg : j_reg;
    assign maxc_new  = (tok.chars > maxc_reg) ? tok.chars : maxc_reg;
    assign used_dp   = used_reg + USED_W'(len_rd_reg) + USED_W'(j_reg != i_reg);
    assign used_sum  = used_reg + USED_W'(len_rd_reg) + USED_W'(k_reg != i_reg);
    assign slack_dp  = WIDTH_W'(USED_W'(w_reg) - used_dp);
    assign dp_last   = ((CNT_W'(j_reg) + CNT_W'(1)) == n_reg);
    assign cost_now  = dp_last ? '0 : COST_W'(prod_reg) + cost_rd_reg;
    assign nxt_raw   = brk_rd_reg;
    assign nxt_fix   = (nxt_raw <= CNT_W'(i_reg) || nxt_raw > n_reg) ? n_reg : nxt_raw;
    assign k_le      = ((CNT_W'(k_reg) + CNT_W'(1)) == nxt_reg);
    assign bonus     = pad_line_reg && !k_le && (bon_reg == '0) && (left_reg != '0);

    always_ff @(posedge clk)
    begin
        len_rd_reg  <= len_mem[len_raddr];
        cost_rd_reg <= cost_mem[IDX_W'(j_reg + IDX_W'(1))];
        brk_rd_reg  <= brk_mem[i_reg];
        if (st_reg == S_LOAD && tok_valid && !tok.drop)
        begin
            len_mem[cnt_reg[IDX_W-1:0]] <= tok.chars;
        end
        if (st_reg == S_DW)
        begin
            cost_mem[i_reg] <= best_reg;
            brk_mem[i_reg]  <= brk_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            maxc_reg    <= '0;
            o_valid_reg <= 1'b0;
            div_go_reg  <= 1'b0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            if (o_valid_reg && res.ready)
            begin
                o_valid_reg <= 1'b0;
            end
            case (st_reg)
                S_LOAD:
                begin
                    if (tok_valid)
                    begin
                        if (tok.drop)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            cnt_reg  <= cnt_reg + CNT_W'(1);
                            maxc_reg <= maxc_new;
                        end
                        if (tok.para_end)
                        begin
                            cnt_reg  <= '0;
                            ovf_reg  <= 1'b0;
                            maxc_reg <= '0;
                            w_reg    <= width;
                            n_reg    <= tok.drop ? cnt_reg : cnt_reg + CNT_W'(1);
                            i_reg    <= cnt_reg[IDX_W-1:0];
                            j_reg    <= cnt_reg[IDX_W-1:0];
                            used_reg <= '0;
                            have_reg <= 1'b0;
                            if (ovf_reg || tok.drop || (WIDTH_W'(maxc_new) > width))
                            begin
                                st_reg <= S_ERR;
                            end
                            else
                            begin
                                st_reg <= S_DA;
                            end
                        end
                    end
                end
                S_ERR:
                begin
                    if (out_free)
                    begin
                        o_valid_reg <= 1'b1;
                        o_extra_reg <= '0;
                        o_le_reg    <= 1'b1;
                        o_lw_reg    <= 1'b1;
                        o_err_reg   <= 1'b1;
                        st_reg      <= S_LOAD;
                    end
                end
                S_DA:
                begin
                    st_reg <= S_DM;
                end
                S_DM:
                begin
                    if (used_dp > USED_W'(w_reg))
                    begin
                        st_reg <= S_DW;
                    end
                    else
                    begin
                        prod_reg <= slack_dp * slack_dp;
                        used_reg <= used_dp;
                        st_reg   <= S_DC;
                    end
                end
                S_DC:
                begin
                    if (!have_reg || cost_now <= best_reg)
                    begin
                        best_reg <= cost_now;
                        brk_reg  <= CNT_W'(j_reg) + CNT_W'(1);
                        have_reg <= 1'b1;
                    end
                    if (dp_last)
                    begin
                        st_reg <= S_DW;
                    end
                    else
                    begin
                        j_reg  <= j_reg + IDX_W'(1);
                        st_reg <= S_DA;
                    end
                end
                S_DW:
                begin
                    if (i_reg == '0)
                    begin
                        st_reg <= S_EA;
                    end
                    else
                    begin
                        i_reg    <= i_reg - IDX_W'(1);
                        j_reg    <= i_reg - IDX_W'(1);
                        used_reg <= '0;
                        have_reg <= 1'b0;
                        st_reg   <= S_DA;
                    end
                end
                S_EA:
                begin
                    st_reg <= S_EB;
                end
                S_EB:
                begin
                    nxt_reg  <= nxt_fix;
                    k_reg    <= i_reg;
                    used_reg <= '0;
                    gaps_reg <= IDX_W'(nxt_fix - CNT_W'(i_reg) - CNT_W'(1));
                    if (nxt_fix < n_reg && (nxt_fix - CNT_W'(i_reg)) > CNT_W'(1))
                    begin
                        pad_line_reg <= 1'b1;
                        st_reg       <= S_SA;
                    end
                    else
                    begin
                        pad_line_reg <= 1'b0;
                        q_reg        <= '0;
                        left_reg     <= '0;
                        bon_reg      <= '0;
                        st_reg       <= S_OUT;
                    end
                end
                S_SA:
                begin
                    st_reg <= S_SC;
                end
                S_SC:
                begin
                    used_reg <= used_sum;
                    if ((CNT_W'(k_reg) + CNT_W'(1)) == nxt_reg)
                    begin
                        k_reg      <= i_reg;
                        div_a_reg  <= (used_sum <= USED_W'(w_reg)) ?
                                      WIDTH_W'(USED_W'(w_reg) - used_sum) : '0;
                        div_b_reg  <= gaps_reg;
                        div_go_reg <= 1'b1;
                        st_reg     <= S_DV1;
                    end
                    else
                    begin
                        k_reg  <= k_reg + IDX_W'(1);
                        st_reg <= S_SA;
                    end
                end
                S_DV1:
                begin
                    if (div_done)
                    begin
                        q_reg <= div_q;
                        r_reg <= div_r;
                        if (div_r != '0)
                        begin
                            div_a_reg  <= WIDTH_W'(gaps_reg);
                            div_b_reg  <= div_r;
                            div_go_reg <= 1'b1;
                            st_reg     <= S_DV2;
                        end
                        else
                        begin
                            left_reg <= '0;
                            bon_reg  <= '0;
                            st_reg   <= S_OUT;
                        end
                    end
                end
                S_DV2:
                begin
                    if (div_done)
                    begin
                        d_reg    <= IDX_W'(div_q);
                        bon_reg  <= IDX_W'(div_q) - IDX_W'(1);
                        left_reg <= r_reg;
                        st_reg   <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        o_valid_reg <= 1'b1;
                        o_extra_reg <= (pad_line_reg && !k_le) ?
                                       q_reg + WIDTH_W'(bonus) : '0;
                        o_le_reg    <= k_le;
                        o_lw_reg    <= ((CNT_W'(k_reg) + CNT_W'(1)) == n_reg);
                        o_err_reg   <= 1'b0;
                        if (bonus)
                        begin
                            bon_reg  <= d_reg - IDX_W'(1);
                            left_reg <= left_reg - IDX_W'(1);
                        end
                        else if (bon_reg != '0)
                        begin
                            bon_reg <= bon_reg - IDX_W'(1);
                        end
                        if (k_le)
                        begin
                            i_reg <= nxt_reg[IDX_W-1:0];
                            if (nxt_reg == n_reg)
                            begin
                                st_reg <= S_LOAD;
                            end
                            else
                            begin
                                st_reg <= S_EA;
                            end
                        end
                        else
                        begin
                            k_reg <= k_reg + IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    st_reg <= S_LOAD;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### test/lbr_tb_ifs.sv
`timescale 1ns / 100ps
// The block's interfaces are in sv/lbr_ifs.sv; this file holds the
// testbench's own helpers shared by the top module.
package lbr_tb_pkg;
    import lbr_pkg::*;

    // One result beat as the predictor produces it.
    typedef struct packed {
        logic [WIDTH_W-1:0] extra_spaces;
        logic               line_end;
        logic               last_word;
        logic               fit_error;
    } layout_beat_t;

    // One row of the directed stimulus.
    typedef struct {
        logic [CHAR_W-1:0]  chars;
        logic               para_end;
        logic [WIDTH_W-1:0] width;
        logic               set_width;
        logic               has_known;
        layout_beat_t       known;
    } word_row_t;
endpackage

### test/tb_min_raggedness_line_breaker.sv
`timescale 1ns / 100ps
module tb_min_raggedness_line_breaker;
    import lbr_pkg::*;
    import lbr_tb_pkg::*;

    localparam int STALL_LIMIT = 200000;

    logic clk;
    logic rst_n;

    lbr_word_if word_in ();
    lbr_res_if  res_out ();
    lbr_cfg_if  cfg ();

    min_raggedness_line_breaker u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .word_in (word_in.sink),
        .res_out (res_out.source),
        .cfg     (cfg.sink)
    );

    // 4 ns clock: two ns high, two ns low.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Predictor state: the words of the open paragraph and the current width.
    logic [CHAR_W-1:0]  para_chars[MAX_WORDS];
    int                 para_count;
    logic               para_overflow;
    logic [WIDTH_W-1:0] cur_width;

    // Expected layout beats, oldest first.
    layout_beat_t layout_queue[$];

    int  failures;
    int  idle_pct;     // percentage of cycles each side idles
    int  quiet_cycles; // cycles with no accepted beat, for the watchdog

    // Solve a closed paragraph and append its beats to the queue.
    task automatic solve_paragraph();
        int unsigned cost[MAX_WORDS];
        int          brk[MAX_WORDS];
        int unsigned pad[MAX_WORDS];
        int unsigned w;
        int          n;
        bit          bad;
        int          i;
        int          j;
        int          k;
        int          nxt;
        int unsigned used;
        int unsigned c;
        int unsigned s;
        int unsigned gaps;
        int unsigned d;
        bit          have;
        layout_beat_t b;
        n = para_count;
        w = cur_width;
        bad = para_overflow;
        para_count = 0;
        para_overflow = 1'b0;
        for (i = 0; i < n; i++)
            if (para_chars[i] > w)
                bad = 1'b1;
        if (bad || n == 0)
        begin
            b = '{extra_spaces: '0, line_end: 1'b1, last_word: 1'b1, fit_error: 1'b1};
            layout_queue.push_back(b);
            return;
        end
        // Backward pass: best cost of setting words i..n-1.
        for (i = n - 1; i >= 0; i--)
        begin
            used = 0;
            have = 1'b0;
            for (j = i; j < n; j++)
            begin
                used += para_chars[j] + ((j > i) ? 1 : 0);
                if (used > w)
                    break;
                if (j + 1 == n)
                    c = 0;
                else
                    c = (w - used) * (w - used) + cost[j + 1];
                // Ties go to the longer line, hence the <=.
                if (!have || c <= cost[i])
                begin
                    cost[i] = c & 32'h7FF_FFFF;
                    brk[i] = j + 1;
                    have = 1'b1;
                end
            end
        end
        for (i = 0; i < n; i++)
            pad[i] = 0;
        i = 0;
        while (i < n)
        begin
            nxt = brk[i];
            if (nxt <= i || nxt > n)
                nxt = n;
            // Only non-last lines with at least one gap are justified.
            if (nxt < n && nxt - i > 1)
            begin
                gaps = nxt - i - 1;
                used = 0;
                for (k = i; k < nxt; k++)
                    used += para_chars[k] + ((k > i) ? 1 : 0);
                s = (used <= w) ? w - used : 0;
                for (k = 0; k < gaps; k++)
                    pad[i + k] = s / gaps;
                s = s % gaps;
                if (s > 0)
                begin
                    d = gaps / s;
                    for (k = d - 1; k < gaps && s > 0; k += d)
                    begin
                        pad[i + k]++;
                        s--;
                    end
                end
            end
            for (j = i; j < nxt; j++)
            begin
                b.extra_spaces = pad[j][WIDTH_W-1:0];
                b.line_end = (j + 1 == nxt);
                b.last_word = (j + 1 == n);
                b.fit_error = 1'b0;
                layout_queue.push_back(b);
            end
            i = nxt;
        end
    endtask

    // Record one accepted word in the predictor.
    task automatic take_word(input logic [CHAR_W-1:0] ch, input logic pe);
        if (para_count < MAX_WORDS)
        begin
            para_chars[para_count] = ch;
            para_count++;
        end
        else
            para_overflow = 1'b1;
        if (pe)
            solve_paragraph();
    endtask

    // Send one word beat, idling at random beforehand. Valid stays up after
    // the beat; the next send or a drain takes it down.
    task automatic send_word(input logic [CHAR_W-1:0] ch, input logic pe);
        while ($urandom_range(99) < idle_pct)
        begin
            word_in.valid <= 1'b0;
            @(negedge clk);
        end
        word_in.valid <= 1'b1;
        word_in.word_chars <= ch;
        word_in.paragraph_end <= pe;
        @(posedge clk);
        while (!word_in.ready)
            @(posedge clk);
        take_word(ch, pe);
        @(negedge clk);
    endtask

    // Wait until every expected beat has come, then let the block settle.
    task automatic drain();
        word_in.valid <= 1'b0;
        while (layout_queue.size() != 0)
            @(negedge clk);
        repeat (100)
            @(negedge clk);
    endtask

    // Width is written only while the block is idle.
    task automatic write_width(input logic [WIDTH_W-1:0] wv);
        cfg.valid <= 1'b1;
        cfg.line_width <= wv;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cur_width = wv;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Result side: random stalls, and every beat checked field by field
    // against the oldest expectation.
    always @(negedge clk)
        if (rst_n)
            res_out.ready <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin
        layout_beat_t exp_b;
        if (rst_n)
        begin
            if (word_in.valid && word_in.ready || res_out.valid && res_out.ready
                || cfg.valid && cfg.ready)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (res_out.valid && res_out.ready)
            begin
                if (layout_queue.size() == 0)
                begin
                    $display("%0t: beat with nothing expected: spaces %0d end %0b last %0b err %0b",
                             $time, res_out.extra_spaces, res_out.line_end,
                             res_out.last_word, res_out.fit_error);
                    failures++;
                end
                else
                begin
                    exp_b = layout_queue.pop_front();
                    if (res_out.extra_spaces !== exp_b.extra_spaces)
                    begin
                        $display("%0t: extra_spaces expected %0d actual %0d",
                                 $time, exp_b.extra_spaces, res_out.extra_spaces);
                        failures++;
                    end
                    if (res_out.line_end !== exp_b.line_end)
                    begin
                        $display("%0t: line_end expected %0b actual %0b",
                                 $time, exp_b.line_end, res_out.line_end);
                        failures++;
                    end
                    if (res_out.last_word !== exp_b.last_word)
                    begin
                        $display("%0t: last_word expected %0b actual %0b",
                                 $time, exp_b.last_word, res_out.last_word);
                        failures++;
                    end
                    if (res_out.fit_error !== exp_b.fit_error)
                    begin
                        $display("%0t: fit_error expected %0b actual %0b",
                                 $time, exp_b.fit_error, res_out.fit_error);
                        failures++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any accepted beat ends the run.
    always @(posedge clk)
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_min_raggedness_line_breaker NOT OK");
            $finish;
        end

    // Directed rows. Known results are given only for error paragraphs,
    // where the single fit_error beat is obvious.
    localparam layout_beat_t ERR_BEAT = '{extra_spaces: '0, line_end: 1'b1,
                                          last_word: 1'b1, fit_error: 1'b1};
    localparam layout_beat_t NO_BEAT = '0;
    word_row_t directed[] = '{
        // Default width 80, a single short word.
        '{8'd1, 1'b1, 10'd0, 1'b0, 1'b0, NO_BEAT},
        // Word of 81 characters against the reset width of 80.
        '{8'd81, 1'b1, 10'd0, 1'b0, 1'b1, ERR_BEAT},
        // Narrowest width: a one-character word fits, a two-character one does not.
        '{8'd1, 1'b0, 10'd1, 1'b1, 1'b0, NO_BEAT},
        '{8'd1, 1'b1, 10'd0, 1'b0, 1'b0, NO_BEAT},
        '{8'd2, 1'b1, 10'd0, 1'b0, 1'b1, ERR_BEAT},
        // Zero-character words at width 1.
        '{8'd0, 1'b0, 10'd0, 1'b0, 1'b0, NO_BEAT},
        '{8'd0, 1'b1, 10'd0, 1'b0, 1'b0, NO_BEAT},
        // Widest width with the largest words.
        '{8'd255, 1'b0, 10'd1023, 1'b1, 1'b0, NO_BEAT},
        '{8'd255, 1'b0, 10'd0, 1'b0, 1'b0, NO_BEAT},
        '{8'd255, 1'b0, 10'd0, 1'b0, 1'b0, NO_BEAT},
        '{8'd255, 1'b0, 10'd0, 1'b0, 1'b0, NO_BEAT},
        '{8'd255, 1'b1, 10'd0, 1'b0, 1'b0, NO_BEAT},
        // Zero width: every nonempty word is an error.
        '{8'd5, 1'b1, 10'd0, 1'b1, 1'b1, ERR_BEAT},
        // Width 20: padded lines with uneven spreading of the slack.
        '{8'd3, 1'b0, 10'd20, 1'b1, 1'b0, NO_BEAT},
        '{8'd4, 1'b0, 10'd0, 1'b0, 1'b0, NO_BEAT},
        '{8'd2, 1'b0, 10'd0, 1'b0, 1'b0, NO_BEAT},
        '{8'd7, 1'b0, 10'd0, 1'b0, 1'b0, NO_BEAT},
        '{8'd1, 1'b0, 10'd0, 1'b0, 1'b0, NO_BEAT},
        '{8'd9, 1'b0, 10'd0, 1'b0, 1'b0, NO_BEAT},
        '{8'd6, 1'b1, 10'd0, 1'b0, 1'b0, NO_BEAT}
    };

    // Send a paragraph of n words; overflow only when asked for.
    task automatic send_paragraph(input int n, input int maxc);
        int i;
        for (i = 0; i < n; i++)
            send_word(CHAR_W'($urandom_range(maxc, 0)), i == n - 1);
    endtask

    initial
    begin
        int r;
        int p;
        int n;
        int lim;
        int wv;
        failures = 0;
        quiet_cycles = 0;
        idle_pct = 16;
        para_count = 0;
        para_overflow = 1'b0;
        cur_width = LINE_WIDTH_RESET;
        rst_n = 1'b0;
        word_in.valid = 1'b0;
        word_in.word_chars = '0;
        word_in.paragraph_end = 1'b0;
        cfg.valid = 1'b0;
        cfg.line_width = '0;
        res_out.ready = 1'b0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (r = 0; r < directed.size(); r++)
        begin
            if (directed[r].set_width)
            begin
                drain();
                write_width(directed[r].width);
            end
            send_word(directed[r].chars, directed[r].para_end);
            // Known rows also check the predictor's last expectation.
            if (directed[r].has_known && layout_queue[$] !== directed[r].known)
            begin
                $display("%0t: row %0d expected %h predicted %h", $time, r,
                         directed[r].known, layout_queue[$]);
                failures++;
            end
        end

        // Too many words: 66 words into a paragraph gives one error beat.
        drain();
        write_width(10'd100);
        send_paragraph(66, 20);

        // Random paragraphs; the width changes between phases.
        for (p = 0; p < 40; p++)
        begin
            if (p % 6 == 0)
            begin
                drain();
                wv = (p == 12) ? 1023 : $urandom_range(60, 8);
                write_width(wv[WIDTH_W-1:0]);
            end
            // A stretch with no idling on either side.
            idle_pct = (p >= 24 && p < 36) ? 0 : 16;
            n = ($urandom_range(9) == 0) ? $urandom_range(64, 30) : $urandom_range(12, 1);
            // Mostly words that fit; occasionally any value at all.
            lim = ($urandom_range(7) == 0) ? 255 : (cur_width < 12 ? cur_width : 12);
            send_paragraph(n, lim);
        end
        drain();
        if (failures == 0)
            $display("tb_min_raggedness_line_breaker OK");
        else
            $display("tb_min_raggedness_line_breaker NOT OK");
        $finish;
    end
endmodule
